[rtl/core/lfu_lru_page_replacement_macros.svh]
// Assertion macros shared by the page replacement RTL.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef LFU_LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LFU_LRU_PAGE_REPLACEMENT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent holds in the same cycle as the antecedent.
`define LFLRU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define LFLRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LFLRU_ASSERT_IMPL(lbl, ante, cons, msg)
`define LFLRU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/lflru_pkg.sv]
package lflru_pkg;

  // Table geometry.
  localparam int NUM_FRAMES = 16;
  localparam int PAGE_BITS  = 8;

  // Fixed field widths.
  localparam int CFG_W       = 5;
  localparam int PAGE_IN_W   = 8;
  localparam int FRAME_OUT_W = 4;
  localparam int EVICT_W     = 8;
  localparam int FAULT_W     = 16;
  localparam int CNT_W       = 16;
  localparam int STAMP_W     = 32;

  // Derived widths.
  localparam int IDX_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int FRAMES_W = $clog2(NUM_FRAMES + 1);
  localparam int ENTRY_W  = PAGE_BITS + CNT_W + STAMP_W;

  // One frame entry as it is held in the table memory.
  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [CNT_W-1:0]     count;
    logic [STAMP_W-1:0]   stamp;
  } entry_t;

  // Control from the sequencer to the scan datapath.
  typedef struct packed {
    logic             start;
    logic             check;
    logic [IDX_W-1:0] idx;
    logic             occupied;
  } scan_ctl_t;

  // Outcome of one pass over the frames.
  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [CNT_W-1:0]     hit_count;
    logic                 empty;
    logic [IDX_W-1:0]     empty_idx;
    logic [IDX_W-1:0]     vic_idx;
    logic [PAGE_BITS-1:0] vic_page;
  } scan_res_t;

endpackage

[rtl/core/lflru_ram.sv]
module lflru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/lflru_scan.sv]
module lflru_scan (
  input  logic                           clk,
  input  logic                           rst,
  input  lflru_pkg::scan_ctl_t           ctl,
  input  logic [lflru_pkg::PAGE_BITS-1:0] page,
  input  lflru_pkg::entry_t              entry,
  output lflru_pkg::scan_res_t           res
);

  import lflru_pkg::*;

  logic [CNT_W-1:0]   best_count;
  logic [STAMP_W-1:0] best_stamp;
  logic               take_victim;

  // The first frame seeds the victim; later frames win only when strictly
  // less used, or equally used and strictly older, so ties keep the lower index.
  always_comb begin
    take_victim = (ctl.idx == '0) || (entry.count < best_count) ||
                  ((entry.count == best_count) && (entry.stamp < best_stamp));
  end

  // Accumulate hit, first empty frame and victim over the frames read.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.hit   <= 1'b0;
      res.empty <= 1'b0;
    end else if (ctl.start) begin
      res.hit   <= 1'b0;
      res.empty <= 1'b0;
    end else if (ctl.check) begin
      if (ctl.occupied && (entry.page == page) && !res.hit) begin
        res.hit       <= 1'b1;
        res.hit_idx   <= ctl.idx;
        res.hit_count <= entry.count;
      end
      if (!ctl.occupied && !res.empty) begin
        res.empty     <= 1'b1;
        res.empty_idx <= ctl.idx;
      end
      if (take_victim) begin
        res.vic_idx  <= ctl.idx;
        res.vic_page <= entry.page;
        best_count   <= entry.count;
        best_stamp   <= entry.stamp;
      end
    end
  end

endmodule

[rtl/core/lfu_lru_page_replacement.sv]
// Fully associative page-frame table with least-frequently-used replacement,
// least-recently-used tie-break and lowest-index final tie-break. Each input
// transfer names one page; one result transfer follows, giving hit or fault,
// the frame now holding the page, any evicted page and the saturating fault
// total. The frame entries live in a single-port-write, registered-read
// memory that is read once per active frame (frames_in_use clamped to
// 1..16). A reference passes an accept step, one read per active frame and
// the memory read latency, a write-back step and a result step that waits
// while the output is stalled, before the block is free again. One
// reference is handled at a time; a finished result waits in the output
// register while the next reference is taken. No clearing pass is needed
// after reset: occupancy is kept in flip-flops that reset clears.
`include "lfu_lru_page_replacement_macros.svh"

module lfu_lru_page_replacement (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lflru_pkg::PAGE_IN_W-1:0]   page_number,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             fault,
  output logic [lflru_pkg::FRAME_OUT_W-1:0] frame_index,
  output logic                             evicted_valid,
  output logic [lflru_pkg::EVICT_W-1:0]     evicted_page,
  output logic [lflru_pkg::FAULT_W-1:0]     fault_total,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lflru_pkg::CFG_W-1:0]       cfg_data
);

  import lflru_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t               state;
  logic [CFG_W-1:0]     frames_in_use;
  logic [NUM_FRAMES-1:0] frame_valid;
  logic [STAMP_W-1:0]   time_stamp;
  logic [FAULT_W-1:0]   fault_counter;
  logic [PAGE_BITS-1:0] page_q;
  logic [IDX_W-1:0]     issue_idx;
  logic                 issuing;
  logic                 chk_valid;
  logic [IDX_W-1:0]     chk_idx;
  logic                 chk_last;

  logic [FRAMES_W-1:0]  n_act;
  logic [IDX_W-1:0]     last_idx;
  logic                 in_xfer;
  logic                 out_free;
  logic                 ram_we;
  logic [IDX_W-1:0]     slot;
  logic                 evict;
  entry_t               wentry;
  entry_t               rentry;
  logic [ENTRY_W-1:0]   ram_rdata;
  scan_ctl_t            scan_ctl;
  scan_res_t            scan_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign ram_we    = (state == S_WRITE);
  assign rentry    = entry_t'(ram_rdata);

  // Clamp the configured frame count into 1..NUM_FRAMES.
  always_comb begin
    if (frames_in_use == '0) begin
      n_act = FRAMES_W'(1);
    end else if (int'(frames_in_use) > NUM_FRAMES) begin
      n_act = FRAMES_W'(NUM_FRAMES);
    end else begin
      n_act = FRAMES_W'(frames_in_use);
    end
    last_idx = IDX_W'(n_act - FRAMES_W'(1));
  end

  // Pick the frame to update and build its new entry.
  always_comb begin
    evict = !scan_res.hit && !scan_res.empty;
    if (scan_res.hit) begin
      slot = scan_res.hit_idx;
    end else if (scan_res.empty) begin
      slot = scan_res.empty_idx;
    end else begin
      slot = scan_res.vic_idx;
    end
    wentry.page  = page_q;
    wentry.stamp = time_stamp;
    if (scan_res.hit) begin
      wentry.count = (scan_res.hit_count == '1) ? scan_res.hit_count
                                                : scan_res.hit_count + 1'b1;
    end else begin
      wentry.count = CNT_W'(1);
    end
  end

  // Scan control for the datapath.
  always_comb begin
    scan_ctl.start    = in_xfer;
    scan_ctl.check    = chk_valid;
    scan_ctl.idx      = chk_idx;
    scan_ctl.occupied = frame_valid[chk_idx];
  end

  lflru_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (wentry),
    .re    (issuing),
    .raddr (issue_idx),
    .rdata (ram_rdata)
  );

  lflru_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .ctl   (scan_ctl),
    .page  (page_q),
    .entry (rentry),
    .res   (scan_res)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      frames_in_use <= cfg_data;
    end
  end

  // Sequencer: accept, read every frame in use, write back, present result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frame_valid   <= '0;
      time_stamp    <= '0;
      fault_counter <= '0;
      issuing       <= 1'b0;
      chk_valid     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // A taken result drops valid unless the finish step loads a new one.
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      chk_valid <= issuing;
      chk_idx   <= issue_idx;
      chk_last  <= (issue_idx == last_idx);
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            page_q     <= PAGE_BITS'(page_number);
            time_stamp <= time_stamp + 1'b1;
            issue_idx  <= '0;
            issuing    <= 1'b1;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issuing) begin
            if (issue_idx == last_idx) begin
              issuing <= 1'b0;
            end else begin
              issue_idx <= issue_idx + 1'b1;
            end
          end
          if (chk_valid && chk_last) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          frame_valid[slot] <= 1'b1;
          if (!scan_res.hit && (fault_counter != '1)) begin
            fault_counter <= fault_counter + 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            fault         <= !scan_res.hit;
            frame_index   <= FRAME_OUT_W'(slot);
            evicted_valid <= evict;
            evicted_page  <= evict ? EVICT_W'(scan_res.vic_page) : '0;
            fault_total   <= fault_counter;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted reference keeps the input side stalled on the next cycle.
  `LFLRU_ASSERT_NEXT(a_busy_after_accept, in_xfer, in_stall, "input not stalled after transfer")
  // The table is written only in the write-back step and never during a read.
  `LFLRU_ASSERT_IMPL(a_no_rw_overlap, ram_we, !issuing && !chk_valid, "table write overlaps read")
  // The fault total never goes backward outside reset.
  `LFLRU_ASSERT_IMPL(a_fault_mono, !$past(rst), fault_counter >= $past(fault_counter), "fault count decreased")
  // A hit never reports an eviction.
  `LFLRU_ASSERT_IMPL(a_hit_no_evict, out_valid && !fault, !evicted_valid && (evicted_page == '0), "eviction reported on hit")

endmodule
